FILE: rtl/case_insensitive_symbol_table_core_defines.svh
// ---------------------------------------------------------------------------
// case_insensitive_symbol_table_core_defines
// assertion macros shared by the symbol table modules
// ---------------------------------------------------------------------------
`ifndef CASE_INSENSITIVE_SYMBOL_TABLE_CORE_DEFINES_SVH
`define CASE_INSENSITIVE_SYMBOL_TABLE_CORE_DEFINES_SVH

// same-cycle implication, checked on i_clk with i_rst_n as disable
`define CIST_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cist: same-cycle check failed");

// next-cycle implication, checked on i_clk with i_rst_n as disable
`define CIST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cist: next-cycle check failed");

`endif

FILE: rtl/cist_pkg.sv
// ---------------------------------------------------------------------------
// cist_pkg
// sizes, codes and shared types of the symbol table core
// ---------------------------------------------------------------------------
package cist_pkg;

    localparam int ENTRY_COUNT = 64;
    localparam int NAME_BYTES  = 8;
    localparam int NAME_W      = 8 * NAME_BYTES;
    localparam int IDX_W       = $clog2(ENTRY_COUNT);
    // priority search runs over slices of the match and free vectors
    localparam int SCAN_W      = (ENTRY_COUNT < 32) ? ENTRY_COUNT : 32;
    localparam int NCHUNK      = (ENTRY_COUNT + SCAN_W - 1) / SCAN_W;
    localparam int PAD_W       = NCHUNK * SCAN_W;
    localparam int CHUNK_W     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int OFF_W       = $clog2(SCAN_W);
    localparam int SLOT_W      = 6;

    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [OFF_W-1:0]   t_off;
    typedef logic [CHUNK_W-1:0] t_chunk;
    typedef logic [NAME_W-1:0]  t_name;
    typedef logic [SLOT_W-1:0]  t_slot;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_DUP   = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_UNDEF = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_LOOKUP = 2'd1,
        MODE_MARK   = 2'd2
    } t_mode;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] sym_name;
    } t_in;

    typedef struct packed {
        t_status status;
        t_slot   slot;
        logic    is_constant;
    } t_out;

    typedef enum logic [1:0] {
        S_IDLE    = 2'd0,
        S_COMPARE = 2'd1,
        S_SCAN    = 2'd2,
        S_COMMIT  = 2'd3
    } t_state;

    typedef struct packed {
        logic capture;
        logic compare;
        logic scan;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic last_chunk;
    } t_dp_stat;

endpackage

FILE: rtl/cist_ctrl.sv
// ---------------------------------------------------------------------------
// cist_ctrl
// request sequencer: capture, compare, slice scan, commit
// ---------------------------------------------------------------------------
`include "case_insensitive_symbol_table_core_defines.svh"

module cist_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cist_pkg::t_dp_cmd  o_cmd,
    input  cist_pkg::t_dp_stat i_stat
);

    cist_pkg::t_state r_state;
    cist_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            cist_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = cist_pkg::S_COMPARE;
                end
            end
            cist_pkg::S_COMPARE: begin
                n_state = cist_pkg::S_SCAN;
            end
            cist_pkg::S_SCAN: begin
                if (i_stat.last_chunk) begin
                    n_state = cist_pkg::S_COMMIT;
                end
            end
            cist_pkg::S_COMMIT: begin
                if (out_free) begin
                    n_state = cist_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cist_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready    = (r_state == cist_pkg::S_IDLE);
        o_cmd.capture = (r_state == cist_pkg::S_IDLE) && i_in_valid;
        o_cmd.compare = (r_state == cist_pkg::S_COMPARE);
        o_cmd.scan    = (r_state == cist_pkg::S_SCAN);
        o_cmd.commit  = (r_state == cist_pkg::S_COMMIT) && out_free;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cist_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `CIST_ASSERT_SAME(a_commit_needs_room, o_cmd.commit, !r_out_valid || i_out_ready)
    `CIST_ASSERT_NEXT(a_commit_shows_word, o_cmd.commit, r_out_valid)
    `CIST_ASSERT_NEXT(a_scan_runs_to_end, r_state == cist_pkg::S_SCAN && !i_stat.last_chunk, r_state == cist_pkg::S_SCAN)

endmodule

FILE: rtl/cist_dp.sv
// ---------------------------------------------------------------------------
// cist_dp
// name cells, parallel compare, sliced priority search and result register
// ---------------------------------------------------------------------------
`include "case_insensitive_symbol_table_core_defines.svh"

module cist_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cist_pkg::t_dp_cmd  i_cmd,
    output cist_pkg::t_dp_stat o_stat,
    input  cist_pkg::t_in      i_in_data,
    output cist_pkg::t_out     o_out_data
);

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // fold A-Z to lower case, drop everything from the first zero byte
    function automatic cist_pkg::t_name fold_name(input logic [63:0] raw);
        cist_pkg::t_name r;
        logic            stop;
        logic [7:0]      b;
        r    = '0;
        stop = 1'b0;
        for (int i = 0; i < cist_pkg::NAME_BYTES; i++) begin
            b = raw[8*i +: 8];
            if (b == 8'h00) begin
                stop = 1'b1;
            end
            if (!stop) begin
                if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
                    b = b + CASE_OFFSET;
                end
                r[8*i +: 8] = b;
            end
        end
        return r;
    endfunction

    // lowest set bit of one slice
    function automatic cist_pkg::t_off first_set(input logic [cist_pkg::SCAN_W-1:0] v);
        cist_pkg::t_off r;
        r = '0;
        for (int i = cist_pkg::SCAN_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = cist_pkg::t_off'(i);
            end
        end
        return r;
    endfunction

    // table state
    logic [cist_pkg::ENTRY_COUNT-1:0] r_used;
    logic [cist_pkg::ENTRY_COUNT-1:0] r_const;
    cist_pkg::t_name                  r_name [cist_pkg::ENTRY_COUNT];

    // request state
    logic [1:0]                 r_mode;
    cist_pkg::t_name            r_key;
    logic [cist_pkg::PAD_W-1:0] r_match;
    logic [cist_pkg::PAD_W-1:0] r_free;
    logic [cist_pkg::PAD_W-1:0] n_match;
    logic [cist_pkg::PAD_W-1:0] n_free;
    cist_pkg::t_chunk           r_chunk;
    logic                       r_hit_found;
    logic                       r_free_found;
    cist_pkg::t_idx             r_hit_idx;
    cist_pkg::t_idx             r_free_idx;
    cist_pkg::t_out             r_out;
    cist_pkg::t_out             n_out;

    logic [cist_pkg::SCAN_W-1:0] m_slice;
    logic [cist_pkg::SCAN_W-1:0] f_slice;
    cist_pkg::t_idx              m_idx;
    cist_pkg::t_idx              f_idx;
    logic                        is_insert;
    logic                        is_mark;
    logic                        do_insert;
    logic                        do_mark;

    // one compare cell per entry
    always_comb begin
        n_match = '0;
        n_free  = '0;
        for (int i = 0; i < cist_pkg::ENTRY_COUNT; i++) begin
            n_match[i] = r_used[i] && (r_name[i] == r_key);
            n_free[i]  = !r_used[i];
        end
    end

    assign m_slice = r_match[cist_pkg::SCAN_W-1:0];
    assign f_slice = r_free[cist_pkg::SCAN_W-1:0];
    assign m_idx   = cist_pkg::t_idx'(int'(r_chunk) * cist_pkg::SCAN_W + int'(first_set(m_slice)));
    assign f_idx   = cist_pkg::t_idx'(int'(r_chunk) * cist_pkg::SCAN_W + int'(first_set(f_slice)));

    assign o_stat.last_chunk = (r_chunk == cist_pkg::t_chunk'(cist_pkg::NCHUNK - 1));

    assign is_insert = (r_mode == cist_pkg::MODE_INSERT);
    assign is_mark   = (r_mode == cist_pkg::MODE_MARK);
    assign do_insert = is_insert && !r_hit_found && r_free_found;
    assign do_mark   = is_mark && r_hit_found;

    always_comb begin
        n_out.status      = cist_pkg::STAT_OK;
        n_out.slot        = '0;
        n_out.is_constant = 1'b0;
        if (is_insert) begin
            if (r_hit_found) begin
                n_out.status = cist_pkg::STAT_DUP;
            end else if (r_free_found) begin
                n_out.slot = cist_pkg::t_slot'(r_free_idx);
            end else begin
                n_out.status = cist_pkg::STAT_FULL;
            end
        end else if (!r_hit_found) begin
            n_out.status = cist_pkg::STAT_UNDEF;
        end else begin
            n_out.slot        = cist_pkg::t_slot'(r_hit_idx);
            n_out.is_constant = is_mark || r_const[r_hit_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used       <= '0;
            r_const      <= '0;
            r_chunk      <= '0;
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            if (i_cmd.compare) begin
                r_chunk      <= '0;
                r_hit_found  <= 1'b0;
                r_free_found <= 1'b0;
            end else if (i_cmd.scan) begin
                r_chunk <= r_chunk + 1'b1;
                if (!r_hit_found && (|m_slice)) begin
                    r_hit_found <= 1'b1;
                end
                if (!r_free_found && (|f_slice)) begin
                    r_free_found <= 1'b1;
                end
            end
            if (i_cmd.commit && do_insert) begin
                r_used[r_free_idx]  <= 1'b1;
                r_const[r_free_idx] <= 1'b0;
            end
            if (i_cmd.commit && do_mark) begin
                r_const[r_hit_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_in_data.mode;
            r_key  <= fold_name(i_in_data.sym_name);
        end
        if (i_cmd.compare) begin
            r_match <= n_match;
            r_free  <= n_free;
        end else if (i_cmd.scan) begin
            r_match <= r_match >> cist_pkg::SCAN_W;
            r_free  <= r_free >> cist_pkg::SCAN_W;
            if (!r_hit_found) begin
                r_hit_idx <= m_idx;
            end
            if (!r_free_found) begin
                r_free_idx <= f_idx;
            end
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
            if (do_insert) begin
                r_name[r_free_idx] <= r_key;
            end
        end
    end

    assign o_out_data = r_out;

    `CIST_ASSERT_SAME(a_hit_in_range, r_hit_found, int'(r_hit_idx) < cist_pkg::ENTRY_COUNT)
    `CIST_ASSERT_SAME(a_insert_into_free, i_cmd.commit && do_insert, !r_used[r_free_idx])
    `CIST_ASSERT_NEXT(a_mark_sets_flag, i_cmd.commit && do_mark, r_const[$past(r_hit_idx)])

endmodule

FILE: rtl/case_insensitive_symbol_table_core.sv
// ---------------------------------------------------------------------------
// case_insensitive_symbol_table_core
// content-addressed symbol table with case-folded names
// ---------------------------------------------------------------------------
// input channel i_in_valid / o_in_ready carries one request word: an
// operation (insert, look up, mark constant) and a zero-padded name
// output channel o_out_valid / i_out_ready returns exactly one result word
// per request: status, slot index and constant flag
// a request runs idle -> compare -> scan -> commit; the scan walks the
// match and free vectors one 32-entry slice a cycle, and a new request
// is accepted only after the commit step of the previous one
// a result word waits in the output register while the next request is
// taken; if the receiver stalls, the commit step holds until the output
// register is free, and the table is not updated before then
// reset clears all used marks and constant flags and empties the output
// register; names are held without reset and are read only once written
// ---------------------------------------------------------------------------
module case_insensitive_symbol_table_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  cist_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output cist_pkg::t_out o_out_data
);

    // command and status between sequencer and datapath
    cist_pkg::t_dp_cmd  dp_cmd;
    cist_pkg::t_dp_stat dp_stat;

    // sequencer: owns the handshakes and the output valid flag
    cist_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (dp_cmd),
        .i_stat      (dp_stat)
    );

    // datapath: name cells, compare, search and result word
    cist_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .o_stat     (dp_stat),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

endmodule
